// ----- design/lap3_pkg.sv -----
// Shared types and constants for the 3x3 Laplacian RGB filter.
// No dependencies; imported by lap3_kernel and the top level.
`default_nettype none

package lap3_pkg;

  localparam int PIX_W = 8;
  localparam int SUM_W = 12;
  localparam int CNT_W = 4;
  localparam int RCP_W = 17;
  localparam int RCP_SH = 16;

  localparam int CH_R = 2;
  localparam int CH_G = 1;
  localparam int CH_B = 0;

  localparam logic [10:0] IMAGE_WIDTH_RST = 11'd640;
  localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [2:0][PIX_W-1:0] rgb_t;

  typedef struct packed {
    logic [2:0] row_m;
    logic [2:0] col_m;
    logic [1:0] wr;
    logic [1:0] wc;
  } sel_t;

  function automatic logic [RCP_W-1:0] lap3_recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    case (cnt)
      4'd2: r = 17'd32768;
      4'd3: r = 17'd21846;
      4'd4: r = 17'd16384;
      4'd5: r = 17'd13108;
      4'd6: r = 17'd10923;
      4'd7: r = 17'd9363;
      4'd8: r = 17'd8192;
      4'd9: r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/lap3_kernel.sv -----
// Kernel sum over the masked 3x3 window and division by the cell count.
// Two registered stages: masked sum, then reciprocal multiply. Uses lap3_pkg.
`default_nettype none

module lap3_kernel import lap3_pkg::*; (
  input  wire logic       clk,
  input  wire logic       sum_en,
  input  wire logic       mul_en,
  input  wire rgb_t [8:0] win,
  input  wire sel_t       sel,
  output rgb_t            q
);

  logic signed [SUM_W-1:0] sum_c [3];
  logic [CNT_W-1:0]        cnt_c;
  logic signed [SUM_W-1:0] sum_r [3];
  logic [CNT_W-1:0]        cnt_r;
  logic [SUM_W-2:0]        mag [3];
  logic [27:0]             prod [3];
  logic [RCP_W-1:0]        rcp;
  logic [PIX_W-1:0]        quo_r [3];
  logic [2:0]              neg_r;

  always_comb begin
    cnt_c = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (sel.row_m[i] && sel.col_m[j]) begin
          cnt_c = cnt_c + 4'd1;
          for (int ch = 0; ch < 3; ch++) begin
            if (2'(i) == sel.wr && 2'(j) == sel.wc) begin
              sum_c[ch] = sum_c[ch] - $signed({1'b0, win[i*3+j][ch], 3'b000});
            end else begin
              sum_c[ch] = sum_c[ch] + $signed({4'b0000, win[i*3+j][ch]});
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_r <= sum_c;
      cnt_r <= cnt_c;
    end
  end

  assign rcp = lap3_recip(cnt_r);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mag[ch]  = sum_r[ch][SUM_W-1] ? (SUM_W-1)'(-sum_r[ch]) : (SUM_W-1)'(sum_r[ch]);
      prod[ch] = 28'(mag[ch]) * 28'(rcp);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        quo_r[ch] <= prod[ch][RCP_SH+PIX_W-1:RCP_SH];
        neg_r[ch] <= sum_r[ch][SUM_W-1];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      q[ch] = neg_r[ch] ? 8'(8'd0 - quo_r[ch]) : quo_r[ch];
    end
  end

endmodule

`default_nettype wire

// ----- design/laplacian_3x3_rgb_filter_top.sv -----
// 3x3 Laplacian RGB filter: line-buffer memory, window, sequencer, APB registers.
// An item gives n = 0..4 results: the line-buffer read on accept, window shift and
// write-back in ST_LOAD, then sum, multiply and output per result; ST_FIN holds
// while the output register is full. A new item is accepted only in ST_IDLE.
// Synchronous reset clears counters, window, sequencer, output valid and sets
// 640x480; the line-buffer memory is not cleared. Uses lap3_pkg, lap3_kernel.
`default_nettype none

module laplacian_3x3_rgb_filter_top import lap3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  in_red_in,
  input  wire logic [PIX_W-1:0]  in_green_in,
  input  wire logic [PIX_W-1:0]  in_blue_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PIX_W-1:0]       out_red_out,
  output logic [PIX_W-1:0]       out_green_out,
  output logic [PIX_W-1:0]       out_blue_out,
  output logic                   out_run_last,
  output logic                   out_frame_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [10:0]     width_r;
  logic [12:0]     height_r;
  logic [WW-1:0]   eff_w;
  logic [12:0]     eff_h;
  logic [CW-1:0]   col_r;
  logic [12:0]     row_r;
  rgb_t            px_r;
  rgb_t [8:0]      win_r;
  logic [47:0]     lb_mem [MAX_WIDTH];
  logic [47:0]     rd_q;
  logic [3:0]      slot_m_r, slot_m_nxt;
  logic [1:0]      slot_sel;
  logic            r_ge1_r, r_ge2_r, c_ge1_r, c_ge2_r;
  logic            last_col, last_row;
  logic            run_last_r, frame_last_r;
  sel_t            sel_r, sel_c;
  rgb_t            kq;
  logic            cfg_wr;
  logic            in_fire, out_free;
  rgb_t            out_pix_r;
  logic            out_valid_r, out_run_last_r, out_frame_last_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (paddr[2])
      REG_IMAGE_HEIGHT: prdata = {19'd0, height_r};
      default:          prdata = {21'd0, width_r};
    endcase
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    eff_h = (height_r == '0) ? 13'd1 : height_r;
  end

  assign last_col = (WW'(col_r) + WW'(1)) == eff_w;
  assign last_row = (row_r + 13'd1) == eff_h;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_q <= lb_mem[col_r];
    end
    if (state_r == ST_LOAD) begin
      lb_mem[col_r] <= {rd_q[23:0], px_r};
    end
  end

  always_comb begin
    slot_sel = 2'd3;
    if (slot_m_r[0]) begin
      slot_sel = 2'd0;
    end else if (slot_m_r[1]) begin
      slot_sel = 2'd1;
    end else if (slot_m_r[2]) begin
      slot_sel = 2'd2;
    end
    sel_c.row_m = slot_sel[0] ? {1'b1, r_ge1_r, 1'b0} : {1'b1, 1'b1, r_ge2_r};
    sel_c.wr    = slot_sel[0] ? 2'd2 : 2'd1;
    sel_c.col_m = slot_sel[1] ? {1'b1, c_ge1_r, 1'b0} : {1'b1, 1'b1, c_ge2_r};
    sel_c.wc    = slot_sel[1] ? 2'd2 : 2'd1;
    slot_m_nxt  = slot_m_r & ~(4'b0001 << slot_sel);
  end

  function automatic logic c_ge1_or_last(input logic [CW-1:0] c, input logic lc);
    return (c != '0) || lc;
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_LOAD;
      ST_LOAD: begin
        state_nxt = ((c_ge1_or_last(col_r, last_col)) && (row_r != '0 || last_row)) ?
                    ST_SUM : ST_IDLE;
      end
      ST_SUM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = (slot_m_r != '0) ? ST_SUM : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      width_r          <= IMAGE_WIDTH_RST;
      height_r         <= IMAGE_HEIGHT_RST;
      col_r            <= '0;
      row_r            <= '0;
      win_r            <= '0;
      slot_m_r         <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (paddr[2])
          REG_IMAGE_HEIGHT: height_r <= pwdata[12:0];
          default:          width_r  <= pwdata[10:0];
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (state_r == ST_LOAD) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? 13'd0 : row_r + 13'd1;
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (state_r == ST_LOAD) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= rd_q[47:24];
        win_r[5] <= rd_q[23:0];
        win_r[8] <= px_r;
        slot_m_r <= {last_col && last_row, last_col && (row_r != '0),
                     (col_r != '0) && last_row, (col_r != '0) && (row_r != '0)};
      end else if (state_r == ST_SUM) begin
        slot_m_r <= slot_m_nxt;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r <= {in_red_in, in_green_in, in_blue_in};
    end
    if (state_r == ST_LOAD) begin
      r_ge1_r <= row_r != '0;
      r_ge2_r <= row_r > 13'd1;
      c_ge1_r <= col_r != '0;
      c_ge2_r <= col_r > CW'(1);
    end
    if (state_r == ST_SUM) begin
      sel_r        <= sel_c;
      run_last_r   <= slot_m_nxt == '0;
      frame_last_r <= slot_sel == 2'd3;
    end
    if (state_r == ST_FIN && out_free) begin
      out_pix_r        <= kq;
      out_run_last_r   <= run_last_r;
      out_frame_last_r <= frame_last_r;
    end
  end

  lap3_kernel u_kernel (
    .clk    (clk),
    .sum_en (state_r == ST_SUM),
    .mul_en (state_r == ST_MUL),
    .win    (win_r),
    .sel    (sel_c),
    .q      (kq)
  );

  assign out_valid      = out_valid_r;
  assign out_red_out    = out_pix_r[CH_R];
  assign out_green_out  = out_pix_r[CH_G];
  assign out_blue_out   = out_pix_r[CH_B];
  assign out_run_last   = out_run_last_r;
  assign out_frame_last = out_frame_last_r;

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < eff_w) else $error("column counter beyond image width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_r < eff_h) else $error("row counter beyond image height");

  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_last_r) |-> out_run_last_r)
    else $error("frame-last result not last of its run");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (slot_m_r == '0))
    else $error("new item accepted with results still pending");

  a_sel_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (sel_r == $past(sel_c)))
    else $error("kernel select changed inside a result");

endmodule

`default_nettype wire
